### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the block's checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with an explicit clock and active-low reset.
`define NBG_ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked assertion on the local clk and rst_n.
`define NBG_ASSERT(label, prop, msg) \
    `NBG_ASSERT_CLK(label, clk, rst_n, prop, msg)

`endif

### rtl/nbg_pkg.sv
// ----------------------------------------------------------------------------
// nbg_pkg
// Types, codes and constants shared by the gravity stepper modules.
// ----------------------------------------------------------------------------
package nbg_pkg;

    // Default body count of the stores.
    localparam int MAX_BODIES_DEF = 16;

    // Request codes.
    localparam logic [1:0] REQ_LOAD  = 2'd0;
    localparam logic [1:0] REQ_TICK  = 2'd1;
    localparam logic [1:0] REQ_PLACE = 2'd2;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_BODIES = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY_GAIN  = 1'b1;

    // Configuration reset values.
    localparam logic [4:0]  ACTIVE_BODIES_RST = 5'd2;
    localparam logic [31:0] GRAVITY_GAIN_RST  = 32'd429497;

    // Width of one signed pair term (magnitude below 2^34).
    localparam int TERM_W = 35;

    // Input item.
    typedef struct packed {
        logic [1:0]         req_type;
        logic [3:0]         body_index;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic [15:0]        body_mass;
    } req_t;

    // Result item.
    typedef struct packed {
        logic [3:0]         out_index;
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic               last_body;
    } rsp_t;

    // Operands of one pair term: separation and the pulling body's mass.
    typedef struct packed {
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic [15:0]        mass;
    } pair_req_t;

    // Acceleration contribution of one pair, Q8.24.
    typedef struct packed {
        logic signed [TERM_W-1:0] cx;
        logic signed [TERM_W-1:0] cy;
    } pair_rsp_t;

endpackage

### rtl/nbg_pair_unit.sv
// ----------------------------------------------------------------------------
// nbg_pair_unit
// Sequenced pair-term unit: one multiplier, a bit-pair square root and a
// restoring divider, reused for every step of one gravity pair term.
// ----------------------------------------------------------------------------
module nbg_pair_unit
    import nbg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  pair_req_t   preq,
    input  logic [31:0] gain,
    output logic        done,
    output pair_rsp_t   prsp
);

    // Sequencer states.
    localparam logic [3:0] P_IDLE = 4'd0;
    localparam logic [3:0] P_KMUL = 4'd1;
    localparam logic [3:0] P_ASQ  = 4'd2;
    localparam logic [3:0] P_BSQ  = 4'd3;
    localparam logic [3:0] P_R2   = 4'd4;
    localparam logic [3:0] P_SQRT = 4'd5;
    localparam logic [3:0] P_DIV  = 4'd6;
    localparam logic [3:0] P_MLO  = 4'd7;
    localparam logic [3:0] P_MHI  = 4'd8;
    localparam logic [3:0] P_MSUM = 4'd9;
    localparam logic [3:0] P_DONE = 4'd10;

    localparam logic [6:0] SQRT_LAST = 7'd31;
    localparam logic [6:0] DIV_LAST  = 7'd71;

    logic [3:0]  state_reg, state_next;
    logic [6:0]  cnt_reg;
    logic [1:0]  pass_reg;
    logic        mpass_reg;

    logic        neg_x_reg, neg_y_reg, half_reg;
    logic [30:0] a_reg, b_reg;
    logic [15:0] mass_reg;
    logic [47:0] k_reg;
    logic [62:0] r2_reg;
    logic [63:0] prod_reg;
    logic [63:0] sq_num_reg;
    logic [33:0] sq_rem_reg;
    logic [31:0] root_reg;
    logic [71:0] dnum_reg;
    logic [63:0] ddiv_reg;
    logic [63:0] drem_reg;
    logic [32:0] dq_reg;
    logic        dovf_reg;
    logic [32:0] v_reg;
    logic [30:0] ux_reg, uy_reg;
    logic [47:0] lo_reg;
    logic signed [TERM_W-1:0] cx_reg, cy_reg;

    // Start-time magnitudes and range halving.
    logic [32:0] mag_x, mag_y;
    logic        half_in;
    logic        zero_in;
    assign mag_x   = preq.dx[32] ? 33'(-preq.dx) : 33'(preq.dx);
    assign mag_y   = preq.dy[32] ? 33'(-preq.dy) : 33'(preq.dy);
    assign half_in = mag_x[32] | mag_x[31] | mag_y[32] | mag_y[31];
    assign zero_in = (preq.dx == 33'sd0) && (preq.dy == 33'sd0);

    // Shared multiplier operand selection.
    logic [31:0] mul_a, mul_b;
    logic [30:0] u_sel;
    assign u_sel = mpass_reg ? uy_reg : ux_reg;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            P_KMUL:
            begin
                mul_a = gain;
                mul_b = {16'b0, mass_reg};
            end
            P_ASQ:
            begin
                mul_a = {1'b0, a_reg};
                mul_b = {1'b0, a_reg};
            end
            P_BSQ:
            begin
                mul_a = {1'b0, b_reg};
                mul_b = {1'b0, b_reg};
            end
            P_MLO:
            begin
                mul_a = {15'b0, v_reg[16:0]};
                mul_b = {1'b0, u_sel};
            end
            P_MHI:
            begin
                mul_a = {16'b0, v_reg[32:17]};
                mul_b = {1'b0, u_sel};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // One square-root step: two radicand bits per cycle.
    logic [35:0] sq_sh, sq_trial;
    logic        sq_ge;
    assign sq_sh    = {sq_rem_reg, sq_num_reg[63:62]};
    assign sq_trial = {2'b0, root_reg, 2'b01};
    assign sq_ge    = sq_sh >= sq_trial;

    // One restoring division step with a saturating quotient.
    logic [64:0] d_sh;
    logic        d_ge;
    logic [64:0] d_diff;
    logic [32:0] d_q_new;
    logic        d_ovf_new;
    logic [32:0] d_res;
    assign d_sh      = {drem_reg, dnum_reg[71]};
    assign d_ge      = d_sh >= {1'b0, ddiv_reg};
    assign d_diff    = d_sh - {1'b0, ddiv_reg};
    assign d_q_new   = {dq_reg[31:0], d_ge};
    assign d_ovf_new = dovf_reg | dq_reg[32];
    assign d_res     = d_ovf_new ? '1 : d_q_new;

    // Product of the split multiply, scaled back to Q8.24.
    logic [65:0] m_full;
    logic [65:0] m_sh;
    logic [33:0] m_mag;
    logic signed [TERM_W-1:0] m_pos, m_neg;
    assign m_full = {1'b0, prod_reg[47:0], 17'b0} + {18'b0, lo_reg};
    assign m_sh   = half_reg ? (m_full >> 32) : (m_full >> 30);
    assign m_mag  = m_sh[33:0];
    assign m_pos  = $signed({1'b0, m_mag});
    assign m_neg  = -m_pos;

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            P_IDLE:  if (start) state_next = zero_in ? P_DONE : P_KMUL;
            P_KMUL:  state_next = P_ASQ;
            P_ASQ:   state_next = P_BSQ;
            P_BSQ:   state_next = P_R2;
            P_R2:    state_next = P_SQRT;
            P_SQRT:  if (cnt_reg == SQRT_LAST) state_next = P_DIV;
            P_DIV:   if (cnt_reg == DIV_LAST && pass_reg == 2'd2) state_next = P_MLO;
            P_MLO:   state_next = P_MHI;
            P_MHI:   state_next = P_MSUM;
            P_MSUM:  state_next = mpass_reg ? P_DONE : P_MLO;
            P_DONE:  state_next = P_IDLE;
            default: state_next = P_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= P_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        unique case (state_reg)
            P_IDLE:
            begin
                neg_x_reg <= preq.dx[32];
                neg_y_reg <= preq.dy[32];
                half_reg  <= half_in;
                a_reg     <= half_in ? mag_x[31:1] : mag_x[30:0];
                b_reg     <= half_in ? mag_y[31:1] : mag_y[30:0];
                mass_reg  <= preq.mass;
                mpass_reg <= 1'b0;
                cx_reg    <= '0;
                cy_reg    <= '0;
            end
            P_ASQ:
            begin
                k_reg <= prod_reg[47:0];
            end
            P_BSQ:
            begin
                r2_reg <= prod_reg[62:0];
            end
            P_R2:
            begin
                r2_reg     <= r2_reg + prod_reg[62:0];
                sq_num_reg <= {1'b0, r2_reg + prod_reg[62:0]};
                sq_rem_reg <= '0;
                root_reg   <= '0;
                cnt_reg    <= '0;
            end
            P_SQRT:
            begin
                sq_num_reg <= {sq_num_reg[61:0], 2'b00};
                sq_rem_reg <= sq_ge ? 34'(sq_sh - sq_trial) : 34'(sq_sh);
                root_reg   <= {root_reg[30:0], sq_ge};
                if (cnt_reg == SQRT_LAST)
                begin
                    // First division: pull factor k * 2^24 / r2.
                    cnt_reg  <= '0;
                    pass_reg <= 2'd0;
                    dnum_reg <= {k_reg, 24'b0};
                    ddiv_reg <= {1'b0, r2_reg};
                    drem_reg <= '0;
                    dq_reg   <= '0;
                    dovf_reg <= 1'b0;
                end
                else
                begin
                    cnt_reg <= cnt_reg + 7'd1;
                end
            end
            P_DIV:
            begin
                if (cnt_reg == DIV_LAST)
                begin
                    cnt_reg  <= '0;
                    drem_reg <= '0;
                    dq_reg   <= '0;
                    dovf_reg <= 1'b0;
                    ddiv_reg <= {32'b0, root_reg};
                    pass_reg <= pass_reg + 2'd1;
                    case (pass_reg)
                        2'd0:
                        begin
                            // Next: unit direction a * 2^30 / r.
                            v_reg    <= d_res;
                            dnum_reg <= {11'b0, a_reg, 30'b0};
                        end
                        2'd1:
                        begin
                            ux_reg   <= d_res[30:0];
                            dnum_reg <= {11'b0, b_reg, 30'b0};
                        end
                        default:
                        begin
                            uy_reg <= d_res[30:0];
                        end
                    endcase
                end
                else
                begin
                    dnum_reg <= {dnum_reg[70:0], 1'b0};
                    drem_reg <= d_ge ? d_diff[63:0] : d_sh[63:0];
                    dq_reg   <= d_q_new;
                    dovf_reg <= d_ovf_new;
                    cnt_reg  <= cnt_reg + 7'd1;
                end
            end
            P_MHI:
            begin
                lo_reg <= prod_reg[47:0];
            end
            P_MSUM:
            begin
                mpass_reg <= 1'b1;
                if (mpass_reg)
                begin
                    cy_reg <= neg_y_reg ? m_neg : m_pos;
                end
                else
                begin
                    cx_reg <= neg_x_reg ? m_neg : m_pos;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign done    = (state_reg == P_DONE);
    assign prsp.cx = cx_reg;
    assign prsp.cy = cy_reg;

endmodule

### rtl/nbody_gravity_step_top.sv
// ----------------------------------------------------------------------------
// nbody_gravity_step_top
// Two-dimensional direct-sum gravity stepper in fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (valid/ready) carries load, place and tick requests; a load or
//   place is written in the cycle of its transfer and req_ready stays high.
//   A tick drops req_ready while it runs: it first sums the pull on every
//   active body from the old positions, then updates velocity and position
//   of each body in index order and sends one rsp transfer per body, the
//   final one with last_body set.
//   cfg channel writes active_bodies and gravity_gain; cfg_ready is always
//   high and writes are meant for an idle block.
//   Each ordered body pair of a tick is worked on one shared datapath (a
//   32-step square root and three divisions); a coincident pair skips the
//   arithmetic and adds nothing to the sums.
//   Reset zeroes the position, velocity and mass stores via per-entry valid
//   bits, with no clearing pass, and restores the configuration defaults.
//   A stalled rsp channel holds the current result; the tick waits at the
//   next result until the output register frees up.
// ----------------------------------------------------------------------------
module nbody_gravity_step_top
    import nbg_pkg::*;
#(
    parameter int MAX_BODIES = MAX_BODIES_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  req_t                 req,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output rsp_t                 rsp,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    localparam int IDX_W = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1;
    localparam int CNT_W = $clog2(MAX_BODIES + 1);
    localparam int SUM_W = TERM_W + $clog2(MAX_BODIES);

    // Tick sequencer states.
    localparam logic [3:0] T_IDLE = 4'd0;
    localparam logic [3:0] T_RDI  = 4'd1;
    localparam logic [3:0] T_LATI = 4'd2;
    localparam logic [3:0] T_RDJ  = 4'd3;
    localparam logic [3:0] T_RDJW = 4'd4;
    localparam logic [3:0] T_PAIR = 4'd5;
    localparam logic [3:0] T_UPRD = 4'd6;
    localparam logic [3:0] T_UVEL = 4'd7;
    localparam logic [3:0] T_UPOS = 4'd8;
    localparam logic [3:0] T_UOUT = 4'd9;

    // Saturate a 33-bit sum to 32 bits.
    function automatic logic [31:0] sat33(input logic [32:0] v);
        logic [31:0] r;
        if (v[32] != v[31])
        begin
            r = v[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Saturate the pair-term sum to 32 bits.
    function automatic logic [31:0] sat_sum(input logic [SUM_W-1:0] v);
        logic [31:0] r;
        if ((&v[SUM_W-1:31]) || !(|v[SUM_W-1:31]))
        begin
            r = v[31:0];
        end
        else
        begin
            r = v[SUM_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        return r;
    endfunction

    logic [3:0]       state_reg, state_next;
    logic [CNT_W-1:0] n_reg, i_reg, j_reg;
    logic [4:0]       active_reg;
    logic [31:0]      gain_reg;

    // Body stores.
    logic [63:0] pos_mem  [MAX_BODIES];
    logic [63:0] vel_mem  [MAX_BODIES];
    logic [63:0] acc_mem  [MAX_BODIES];
    logic [15:0] mass_mem [MAX_BODIES];
    logic [MAX_BODIES-1:0] body_vld_reg, mass_vld_reg;

    logic [63:0] pos_rd_reg, vel_rd_reg, acc_rd_reg;
    logic [15:0] mass_rd_reg;
    logic        body_vld_rd_reg, mass_vld_rd_reg;

    logic signed [31:0] pi_x_reg, pi_y_reg;
    logic [SUM_W-1:0]   sum_x_reg, sum_y_reg;
    logic [31:0]        upd_vx_reg, upd_vy_reg, upd_px_reg, upd_py_reg;
    logic               rsp_valid_reg;
    rsp_t               rsp_reg;

    // Request decode.
    logic             req_xfer;
    logic             in_range;
    logic [IDX_W-1:0] req_addr;
    logic             load_we;
    logic [CNT_W-1:0] n_eff;
    assign req_ready = (state_reg == T_IDLE);
    assign req_xfer  = req_valid && req_ready;
    assign in_range  = 32'(req.body_index) < 32'(MAX_BODIES);
    assign req_addr  = IDX_W'(req.body_index);
    assign load_we   = req_xfer && in_range &&
                       (req.req_type == REQ_LOAD || req.req_type == REQ_PLACE);
    assign n_eff     = (32'(active_reg) > 32'(MAX_BODIES)) ? CNT_W'(MAX_BODIES)
                                                           : CNT_W'(active_reg);

    // Store reads with reset-value substitution.
    logic [CNT_W-1:0]   rd_cnt;
    logic [IDX_W-1:0]   rd_addr;
    logic [63:0]        pos_rd, vel_rd;
    logic [15:0]        mass_rd;
    assign rd_cnt  = (state_reg == T_RDJ) ? j_reg : i_reg;
    assign rd_addr = rd_cnt[IDX_W-1:0];
    assign pos_rd  = body_vld_rd_reg ? pos_rd_reg : '0;
    assign vel_rd  = body_vld_rd_reg ? vel_rd_reg : '0;
    assign mass_rd = mass_vld_rd_reg ? mass_rd_reg : '0;

    // Pair-term unit.
    logic      pair_start, pair_done;
    pair_req_t pair_req;
    pair_rsp_t pair_rsp;
    assign pair_start    = (state_reg == T_RDJW);
    assign pair_req.dx   = 33'($signed(pos_rd[63:32])) - 33'(pi_x_reg);
    assign pair_req.dy   = 33'($signed(pos_rd[31:0])) - 33'(pi_y_reg);
    assign pair_req.mass = mass_rd;

    nbg_pair_unit u_pair (
        .clk   (clk),
        .rst_n (rst_n),
        .start (pair_start),
        .preq  (pair_req),
        .gain  (gain_reg),
        .done  (pair_done),
        .prsp  (pair_rsp)
    );

    // Store write selection.
    logic             out_free;
    logic             upd_we;
    logic             body_we;
    logic [IDX_W-1:0] body_waddr;
    logic [63:0]      pos_wdata, vel_wdata;
    logic             acc_we;
    logic             last_i;
    assign out_free   = !rsp_valid_reg || rsp_ready;
    assign upd_we     = (state_reg == T_UOUT) && out_free;
    assign body_we    = load_we || upd_we;
    assign body_waddr = load_we ? req_addr : i_reg[IDX_W-1:0];
    assign pos_wdata  = load_we ? {req.pos_x, req.pos_y} : {upd_px_reg, upd_py_reg};
    assign vel_wdata  = load_we ? 64'b0 : {upd_vx_reg, upd_vy_reg};
    assign acc_we     = (state_reg == T_RDJ) && (j_reg == n_reg);
    assign last_i     = (i_reg == n_reg - CNT_W'(1));

    always_ff @(posedge clk)
    begin
        if (body_we)
        begin
            pos_mem[body_waddr] <= pos_wdata;
            vel_mem[body_waddr] <= vel_wdata;
        end
        if (load_we && req.req_type == REQ_LOAD)
        begin
            mass_mem[req_addr] <= req.body_mass;
        end
        if (acc_we)
        begin
            acc_mem[i_reg[IDX_W-1:0]] <= {sat_sum(sum_x_reg), sat_sum(sum_y_reg)};
        end
        pos_rd_reg      <= pos_mem[rd_addr];
        vel_rd_reg      <= vel_mem[rd_addr];
        acc_rd_reg      <= acc_mem[rd_addr];
        mass_rd_reg     <= mass_mem[rd_addr];
        body_vld_rd_reg <= body_vld_reg[rd_addr];
        mass_vld_rd_reg <= mass_vld_reg[rd_addr];
    end

    // Valid bits stand for the all-zero reset contents.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            body_vld_reg <= '0;
            mass_vld_reg <= '0;
        end
        else
        begin
            if (body_we)
            begin
                body_vld_reg[body_waddr] <= 1'b1;
            end
            if (load_we && req.req_type == REQ_LOAD)
            begin
                mass_vld_reg[req_addr] <= 1'b1;
            end
        end
    end

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= ACTIVE_BODIES_RST;
            gain_reg   <= GRAVITY_GAIN_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_ACTIVE_BODIES: active_reg <= cfg_data[4:0];
                CFG_GRAVITY_GAIN:  gain_reg   <= cfg_data;
                default:           gain_reg   <= gain_reg;
            endcase
        end
    end

    // Tick sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            T_IDLE:
            begin
                if (req_xfer && req.req_type == REQ_TICK && n_eff != '0)
                begin
                    state_next = T_RDI;
                end
            end
            T_RDI:  state_next = T_LATI;
            T_LATI: state_next = T_RDJ;
            T_RDJ:
            begin
                if (j_reg == n_reg)
                begin
                    state_next = last_i ? T_UPRD : T_RDI;
                end
                else if (j_reg != i_reg)
                begin
                    state_next = T_RDJW;
                end
            end
            T_RDJW: state_next = T_PAIR;
            T_PAIR: if (pair_done) state_next = T_RDJ;
            T_UPRD: state_next = T_UVEL;
            T_UVEL: state_next = T_UPOS;
            T_UPOS: state_next = T_UOUT;
            T_UOUT: if (out_free) state_next = last_i ? T_IDLE : T_UPRD;
            default: state_next = T_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= T_IDLE;
            n_reg     <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                T_IDLE:
                begin
                    n_reg <= n_eff;
                    i_reg <= '0;
                end
                T_RDI:
                begin
                    j_reg <= '0;
                end
                T_RDJ:
                begin
                    if (j_reg == n_reg)
                    begin
                        i_reg <= last_i ? '0 : i_reg + CNT_W'(1);
                    end
                    else if (j_reg == i_reg)
                    begin
                        j_reg <= j_reg + CNT_W'(1);
                    end
                end
                T_PAIR:
                begin
                    if (pair_done)
                    begin
                        j_reg <= j_reg + CNT_W'(1);
                    end
                end
                T_UOUT:
                begin
                    if (out_free && !last_i)
                    begin
                        i_reg <= i_reg + CNT_W'(1);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Acceleration sums and per-body update arithmetic.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            T_RDI:
            begin
                sum_x_reg <= '0;
                sum_y_reg <= '0;
            end
            T_LATI:
            begin
                pi_x_reg <= $signed(pos_rd[63:32]);
                pi_y_reg <= $signed(pos_rd[31:0]);
            end
            T_PAIR:
            begin
                if (pair_done)
                begin
                    sum_x_reg <= sum_x_reg +
                        {{(SUM_W-TERM_W){pair_rsp.cx[TERM_W-1]}}, pair_rsp.cx};
                    sum_y_reg <= sum_y_reg +
                        {{(SUM_W-TERM_W){pair_rsp.cy[TERM_W-1]}}, pair_rsp.cy};
                end
            end
            T_UVEL:
            begin
                upd_vx_reg <= sat33({vel_rd[63], vel_rd[63:32]} +
                                    {acc_rd_reg[63], acc_rd_reg[63:32]});
                upd_vy_reg <= sat33({vel_rd[31], vel_rd[31:0]} +
                                    {acc_rd_reg[31], acc_rd_reg[31:0]});
                upd_px_reg <= pos_rd[63:32];
                upd_py_reg <= pos_rd[31:0];
            end
            T_UPOS:
            begin
                // Q8.24 velocity to Q16.16 step, rounding toward minus infinity.
                upd_px_reg <= sat33({upd_px_reg[31], upd_px_reg} +
                                    {{9{upd_vx_reg[31]}}, upd_vx_reg[31:8]});
                upd_py_reg <= sat33({upd_py_reg[31], upd_py_reg} +
                                    {{9{upd_vy_reg[31]}}, upd_vy_reg[31:8]});
            end
            default:
            begin
            end
        endcase
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (upd_we)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (upd_we)
        begin
            rsp_reg.out_index <= 4'(i_reg);
            rsp_reg.out_x     <= upd_px_reg;
            rsp_reg.out_y     <= upd_py_reg;
            rsp_reg.last_body <= last_i;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

### rtl/nbg_checker.sv
// ----------------------------------------------------------------------------
// nbg_checker
// Port-level assertions for the gravity stepper, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nbg_checker
    import nbg_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input req_t req,
    input logic rsp_valid,
    input logic rsp_ready,
    input rsp_t rsp
);

    // A stalled result holds its value.
    `NBG_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp), "rsp changed while stalled")

    // Only a tick transfer can take the block out of idle.
    `NBG_ASSERT(a_ready_keep, req_ready && !(req_valid && req.req_type == REQ_TICK) |=> req_ready, "req_ready dropped without a tick")

    // An idle block with a free output produces no result.
    `NBG_ASSERT(a_no_spurious, req_ready && (!rsp_valid || rsp_ready) |=> !rsp_valid, "result appeared while idle")

    // While a non-final result is pending, the tick is still running.
    `NBG_ASSERT(a_busy_mid_tick, rsp_valid && !rsp.last_body |-> !req_ready, "block idle before final result")

endmodule

bind nbody_gravity_step_top nbg_checker u_nbg_checker (.*);
